FILE: hdl/assert_macros.svh
// Assertion macros shared by the converter RTL.
// Expand to concurrent assertions in simulation and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

FILE: hdl/ittp_pkg.sv
// Types and constants of the infix to postfix converter.
// Used by the front end, the token queue and the stack engine.
package ittp_pkg;

  typedef enum logic [2:0] {
    TK_OPERAND = 3'd0,
    TK_PLUS    = 3'd1,
    TK_MINUS   = 3'd2,
    TK_TIMES   = 3'd3,
    TK_LPAREN  = 3'd4,
    TK_RPAREN  = 3'd5,
    TK_END     = 3'd6
  } tok_kind_e;

  // On the stack OP_NONE marks a left paren; on the output it marks an operand or an error result.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_PLUS  = 2'd1,
    OP_MINUS = 2'd2,
    OP_TIMES = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_OVERFLOW    = 2'd1,
    ST_UNMATCHED_R = 2'd2,
    ST_UNMATCHED_L = 2'd3
  } status_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } bk_state_e;

  typedef struct packed {
    tok_kind_e          kind;
    logic signed [31:0] value;
  } tok_t;

  typedef struct packed {
    op_e                kind;
    logic signed [31:0] value;
    status_e            status;
  } res_t;

  typedef struct packed {
    logic take;
    logic emit;
    logic pop;
    logic push;
    logic done;
    logic flush;
    op_e  push_ent;
    res_t res;
  } bk_ctrl_t;

  function automatic logic prec_hi(op_e op);
    return op == OP_TIMES;
  endfunction

endpackage

FILE: hdl/ittp_front.sv
// Front end: input register that accepts tokens and drops undefined kinds.
// Depends on ittp_pkg; feeds ittp_queue.
module ittp_front import ittp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  token_kind_i,
  input  logic [31:0] operand_value_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        q_full_i,
  output logic        q_push_o,
  output tok_t        q_data_o
);

  logic fr_v_q, fr_v_d;
  tok_t fr_q;
  logic accept;
  logic known;

  assign known      = token_kind_i <= TK_END;
  assign q_push_o   = fr_v_q && !q_full_i;
  assign in_ready_o = !fr_v_q || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_data_o   = fr_q;

  always_comb begin
    fr_v_d = fr_v_q;
    if (q_push_o) begin
      fr_v_d = 1'b0;
    end
    if (accept && known) begin
      fr_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_v_q <= 1'b0;
    end else begin
      fr_v_q <= fr_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && known) begin
      fr_q.kind  <= tok_kind_e'(token_kind_i);
      fr_q.value <= operand_value_i;
    end
  end

endmodule

FILE: hdl/ittp_queue.sv
// Two-entry token queue between the front end and the stack engine.
// Depends on ittp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ittp_queue import ittp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  tok_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output tok_t pop_data_o,
  output logic empty_o
);

  localparam logic [1:0] QDepth = 2'd2;

  tok_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = cnt_q == QDepth;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ASSERT_NEVER(a_q_over, clk_i, rst_ni, push_i && full_o, "push into full token queue")
  `ASSERT_NEVER(a_q_under, clk_i, rst_ni, pop_i && empty_o, "pop from empty token queue")
  `ASSERT_CLK(a_q_cnt, clk_i, rst_ni, cnt_q <= QDepth, "token queue count out of range")

endmodule

FILE: hdl/ittp_back.sv
// Stack engine: operator stack memory, sequencer, one-result hold and output register.
// Depends on ittp_pkg and assert_macros.svh; drains ittp_queue.
`include "assert_macros.svh"
module ittp_back import ittp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  tok_t               q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_kind_o,
  output logic signed [31:0] out_value_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  localparam int unsigned IdxW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  bk_state_e     state_q, state_d;
  bk_ctrl_t      ctl;
  tok_t          cur_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  op_e           mem [STACK_DEPTH];
  op_e           rd_q, byp_q, top, cur_op;
  logic          byp_v_q;
  logic [IdxW-1:0] rd_addr;
  logic          pend_v_q;
  res_t          pend_q, out_q;
  logic          out_v_q, out_last_q;
  logic          out_free, go, emit_g, push_g, pop_g, out_ld, cnt_full, cnt_zero;

  assign top      = byp_v_q ? byp_q : rd_q;
  assign cur_op   = op_e'(cur_q.kind[1:0]);
  assign cnt_full = cnt_q == CntW'(STACK_DEPTH);
  assign cnt_zero = cnt_q == '0;
  assign out_free = !out_v_q || out_ready_i;

  always_comb begin
    ctl          = '0;
    ctl.push_ent = OP_NONE;
    ctl.res      = '{kind: OP_NONE, value: '0, status: ST_OK};
    case (state_q)
      BK_IDLE: begin
        if (pend_v_q) begin
          ctl.flush = out_free;
          ctl.take  = out_free && !q_empty_i;
        end else begin
          ctl.take = !q_empty_i;
        end
      end
      BK_RUN: begin
        case (cur_q.kind)
          TK_OPERAND: begin
            ctl.emit      = 1'b1;
            ctl.res.value = cur_q.value;
            ctl.done      = 1'b1;
          end
          TK_PLUS, TK_MINUS, TK_TIMES: begin
            if (!cnt_zero && top != OP_NONE && (prec_hi(top) || !prec_hi(cur_op))) begin
              ctl.emit     = 1'b1;
              ctl.res.kind = top;
              ctl.pop      = 1'b1;
            end else if (cnt_full) begin
              ctl.emit       = 1'b1;
              ctl.res.status = ST_OVERFLOW;
              ctl.done       = 1'b1;
            end else begin
              ctl.push     = 1'b1;
              ctl.push_ent = cur_op;
              ctl.done     = 1'b1;
            end
          end
          TK_LPAREN: begin
            if (cnt_full) begin
              ctl.emit       = 1'b1;
              ctl.res.status = ST_OVERFLOW;
            end else begin
              ctl.push = 1'b1;
            end
            ctl.done = 1'b1;
          end
          TK_RPAREN: begin
            if (cnt_zero) begin
              ctl.emit       = 1'b1;
              ctl.res.status = ST_UNMATCHED_R;
              ctl.done       = 1'b1;
            end else if (top == OP_NONE) begin
              ctl.pop  = 1'b1;
              ctl.done = 1'b1;
            end else begin
              ctl.emit     = 1'b1;
              ctl.res.kind = top;
              ctl.pop      = 1'b1;
            end
          end
          TK_END: begin
            if (cnt_zero) begin
              ctl.done = 1'b1;
            end else begin
              ctl.pop  = 1'b1;
              ctl.emit = 1'b1;
              if (top == OP_NONE) begin
                ctl.res.status = ST_UNMATCHED_L;
              end else begin
                ctl.res.kind = top;
              end
            end
          end
          default: begin
            ctl.done = 1'b1;
          end
        endcase
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (ctl.take) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (ctl.done && go) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  assign go      = !(ctl.emit && pend_v_q && !out_free);
  assign emit_g  = ctl.emit && go;
  assign push_g  = ctl.push && go;
  assign pop_g   = ctl.pop && go;
  assign out_ld  = ctl.flush || (emit_g && pend_v_q);
  assign q_pop_o = ctl.take;

  always_comb begin
    cnt_d = cnt_q;
    if (push_g) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_g) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  assign rd_addr = IdxW'(cnt_d - CntW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      cnt_q    <= '0;
      byp_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      byp_v_q <= push_g;
      if (emit_g) begin
        pend_v_q <= 1'b1;
      end else if (ctl.flush) begin
        pend_v_q <= 1'b0;
      end
      if (out_ld) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.take) begin
      cur_q <= q_data_i;
    end
    if (emit_g) begin
      pend_q <= ctl.res;
    end
    if (out_ld) begin
      out_q      <= pend_q;
      out_last_q <= ctl.flush;
    end
    byp_q <= ctl.push_ent;
  end

  always_ff @(posedge clk_i) begin
    if (push_g) begin
      mem[cnt_q[IdxW-1:0]] <= ctl.push_ent;
    end
    rd_q <= mem[rd_addr];
  end

  assign out_valid_o = out_v_q;
  assign out_kind_o  = out_q.kind;
  assign out_value_o = out_q.value;
  assign status_o    = out_q.status;
  assign last_o      = out_last_q;

  `ASSERT_CLK(a_bk_cnt, clk_i, rst_ni, cnt_q <= CntW'(STACK_DEPTH), "stack count beyond depth")
  `ASSERT_NEVER(a_bk_push_full, clk_i, rst_ni, push_g && cnt_full, "push onto full stack")
  `ASSERT_NEVER(a_bk_pop_empty, clk_i, rst_ni, pop_g && cnt_zero, "pop from empty stack")
  `ASSERT_NEVER(a_bk_out_ovr, clk_i, rst_ni, out_ld && !out_free, "output overwritten")

endmodule

FILE: hdl/infix_to_postfix_converter.sv
// The stack engine works on one item at a time and pops one stack entry per cycle,
// unless the output stalls, from a registered-read memory; the left paren that a right
// paren closes is popped as that item finishes.
// The final result of an item is held one step until the next result or item end.
// Reset clears all control state and the stack count; stack contents are not cleared.
module infix_to_postfix_converter import ittp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         token_kind_i,
  input  logic signed [31:0] operand_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_kind_o,
  output logic signed [31:0] out_value_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  logic q_push, q_full, q_pop, q_empty;
  tok_t q_wdata, q_rdata;

  ittp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .token_kind_i    (token_kind_i),
    .operand_value_i (operand_value_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (q_wdata)
  );

  ittp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  ittp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_kind_o  (out_kind_o),
    .out_value_o (out_value_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
